[src/binomial_transform_top_defines.svh]
// Assertion macros shared by the binomial transform checker
`ifndef BINOMIAL_TRANSFORM_TOP_DEFINES_SVH
`define BINOMIAL_TRANSFORM_TOP_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define BT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("binomial transform check failed");

// next-cycle implication, disabled while in reset
`define BT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("binomial transform check failed");

`endif

[src/bt_pkg.sv]
// Shared widths, defaults and control struct for the binomial transform
package bt_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int ROW_W       = 13;
  localparam int COEF_W      = 30;
  localparam int INDEX_W     = 4;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 40;
  localparam int OUT_PAD_W   = OUT_TDATA_W - COEF_W - INDEX_W;
  localparam int MAX_LEN_DEF = 16;

  // broadcast to every cell
  typedef struct packed {
    logic upd;    // sample beat accepted
    logic clear;  // reload Pascal row after this beat
    logic shift;  // output beat: accumulators move one cell down
    logic dir;    // 1: inverse transform
  } bt_ctrl_t;

endpackage

[src/bt_cell.sv]
// One coefficient cell: Pascal entry, accumulator and shift path
module bt_cell (
  input  logic                               clk,
  input  logic                               rst_n,
  input  bt_pkg::bt_ctrl_t                   ctrl,
  input  logic                               init_one,
  input  logic                               active,
  input  logic                               odd_pos,
  input  logic signed [bt_pkg::SAMPLE_W-1:0] sample,
  input  logic        [bt_pkg::ROW_W-1:0]    row_left,
  input  logic signed [bt_pkg::COEF_W-1:0]   acc_right,
  output logic        [bt_pkg::ROW_W-1:0]    row,
  output logic signed [bt_pkg::COEF_W-1:0]   acc
);

  logic        [bt_pkg::ROW_W-1:0]  row_r, row_nxt, row_new;
  logic signed [bt_pkg::COEF_W-1:0] acc_r, acc_nxt, prod, term, acc_sat;
  logic signed [bt_pkg::COEF_W:0]   sum;

  // row entry wraps modulo 2^ROW_W
  assign row_new = row_r + row_left;
  assign prod    = bt_pkg::COEF_W'(sample) * bt_pkg::COEF_W'($signed({1'b0, row_new}));
  assign term    = (ctrl.dir && odd_pos) ? -prod : prod;
  assign sum     = {acc_r[bt_pkg::COEF_W-1], acc_r} + {term[bt_pkg::COEF_W-1], term};

  always_comb begin
    if (sum[bt_pkg::COEF_W] != sum[bt_pkg::COEF_W-1]) begin
      acc_sat = sum[bt_pkg::COEF_W] ? {1'b1, {(bt_pkg::COEF_W-1){1'b0}}}
                                    : {1'b0, {(bt_pkg::COEF_W-1){1'b1}}};
    end else begin
      acc_sat = sum[bt_pkg::COEF_W-1:0];
    end
  end

  always_comb begin
    row_nxt = row_r;
    acc_nxt = acc_r;
    if (ctrl.upd) begin
      if (active) begin
        row_nxt = row_new;
        acc_nxt = acc_sat;
      end
      if (ctrl.clear) begin
        row_nxt = {{(bt_pkg::ROW_W-1){1'b0}}, init_one};
      end
    end else if (ctrl.shift) begin
      acc_nxt = acc_right;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= {{(bt_pkg::ROW_W-1){1'b0}}, init_one};
      acc_r <= '0;
    end else begin
      row_r <= row_nxt;
      acc_r <= acc_nxt;
    end
  end

  assign row = row_r;
  assign acc = acc_r;

endmodule

[src/binomial_transform_top.sv]
// Streaming binomial transform: a row of coefficient cells plus beat control
//
// Input channel in_*: one signed 16-bit sample per beat, in_tlast on the final
// sample of a vector. The MAX_LEN-th sample closes the vector even without
// in_tlast. Samples are taken one per cycle while in_tready is high; every
// active cell (index up to the sample's position) updates its Pascal entry and
// accumulator in the same cycle.
// Output channel out_*: after the closing sample, n coefficient beats leave in
// index order, the first valid in the cycle after the closing sample, then one
// per cycle while out_tready is high; out_tlast marks the final one. The
// accumulators shift one cell toward cell 0 per output beat, which also clears
// them. in_tready is low while a vector is being emitted, so no sample of the
// next vector is taken until the final coefficient beat has been accepted.
// Receiver stall: the current coefficient beat holds unchanged until taken.
// Reset (rst_n low, synchronous): empty vector, direction forward, no output.
// cfg_we writes the direction bit (0 forward, 1 inverse); the cells read it on
// every sample beat.
module binomial_transform_top #(
  parameter int MAX_LEN = bt_pkg::MAX_LEN_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic                             cfg_wdata,    // direction
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [bt_pkg::IN_TDATA_W-1:0]    in_tdata,     // [15:0] sample
  input  logic                             in_tlast,     // last
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [bt_pkg::OUT_TDATA_W-1:0]   out_tdata,    // [29:0] coefficient, [33:30] index
  output logic                             out_tlast     // last_out
);

  localparam int CNT_W = $clog2(MAX_LEN + 1);

  logic             dir_r;
  logic             emit_r, emit_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] emit_idx_r, emit_idx_nxt;
  logic [CNT_W-1:0] emit_len_r, emit_len_nxt;
  logic             in_beat, out_beat, close_beat;
  bt_pkg::bt_ctrl_t ctrl;

  logic        [bt_pkg::ROW_W-1:0]  row_w [MAX_LEN];
  logic signed [bt_pkg::COEF_W-1:0] acc_w [MAX_LEN];
  logic        [bt_pkg::INDEX_W-1:0] idx_out;

  assign in_tready  = !emit_r;
  assign in_beat    = in_tvalid && in_tready;
  assign out_tvalid = emit_r;
  assign out_beat   = out_tvalid && out_tready;
  assign out_tlast  = (emit_idx_r == emit_len_r);
  assign close_beat = in_beat && (in_tlast || (count_r == CNT_W'(MAX_LEN - 1)));

  assign ctrl.upd   = in_beat;
  assign ctrl.clear = close_beat;
  assign ctrl.shift = out_beat;
  assign ctrl.dir   = dir_r;

  for (genvar j = 0; j < MAX_LEN; j++) begin : g_cell
    logic                       active;
    logic                       odd_pos;
    logic [bt_pkg::ROW_W-1:0]   left;
    logic signed [bt_pkg::COEF_W-1:0] right;

    assign active  = (count_r >= CNT_W'(j));
    assign odd_pos = count_r[0] ^ (j % 2 == 1);

    if (j == 0) begin : g_left0
      assign left = '0;
    end else begin : g_left
      assign left = row_w[j-1];
    end

    if (j == MAX_LEN - 1) begin : g_right_end
      assign right = '0;
    end else begin : g_right
      assign right = acc_w[j+1];
    end

    bt_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .init_one  (j == 0),
      .active    (active),
      .odd_pos   (odd_pos),
      .sample    ($signed(in_tdata[bt_pkg::SAMPLE_W-1:0])),
      .row_left  (left),
      .acc_right (right),
      .row       (row_w[j]),
      .acc       (acc_w[j])
    );
  end

  always_comb begin
    emit_nxt     = emit_r;
    count_nxt    = count_r;
    emit_idx_nxt = emit_idx_r;
    emit_len_nxt = emit_len_r;
    if (close_beat) begin
      emit_nxt     = 1'b1;
      emit_len_nxt = count_r;
      emit_idx_nxt = '0;
      count_nxt    = '0;
    end else if (in_beat) begin
      count_nxt = count_r + 1'b1;
    end else if (out_beat) begin
      if (out_tlast) begin
        emit_nxt = 1'b0;
      end else begin
        emit_idx_nxt = emit_idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r      <= 1'b0;
      emit_r     <= 1'b0;
      count_r    <= '0;
      emit_idx_r <= '0;
      emit_len_r <= '0;
    end else begin
      if (cfg_we) begin
        dir_r <= cfg_wdata;
      end
      emit_r     <= emit_nxt;
      count_r    <= count_nxt;
      emit_idx_r <= emit_idx_nxt;
      emit_len_r <= emit_len_nxt;
    end
  end

  assign idx_out   = bt_pkg::INDEX_W'(emit_idx_r);
  assign out_tdata = {{bt_pkg::OUT_PAD_W{1'b0}}, idx_out, acc_w[0]};

endmodule

[src/bt_checker.sv]
// Port-level checks for the binomial transform, bound to the top level
`include "binomial_transform_top_defines.svh"

module bt_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic                           in_tlast,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [bt_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                           out_tlast
);

  // no sample is taken while coefficients are leaving
  `BT_ASSERT_NOW(a_no_overlap, in_tready, !out_tvalid)
  // a closing sample with in_tlast starts emission on the next cycle
  `BT_ASSERT_NEXT(a_emit_start, in_tvalid && in_tready && in_tlast, out_tvalid)
  // emission always starts at index zero
  `BT_ASSERT_NOW(a_first_index, $rose(out_tvalid), out_tdata[33:30] == 4'd0)
  // stalled beat holds
  `BT_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready,
                  out_tvalid && $stable(out_tdata) && $stable(out_tlast))
  // the final coefficient ends emission
  `BT_ASSERT_NEXT(a_emit_end, out_tvalid && out_tready && out_tlast, !out_tvalid)

endmodule

bind binomial_transform_top bt_checker u_bt_checker (.*);

[test/binomial_transform_top_tb.sv]
// Self-checking testbench for binomial_transform_top: directed and random stream traffic vs a bit-exact predictor
module binomial_transform_top_tb;

  localparam int SAMPLE_W     = bt_pkg::SAMPLE_W;
  localparam int ROW_W        = bt_pkg::ROW_W;
  localparam int COEF_W       = bt_pkg::COEF_W;
  localparam int INDEX_W      = bt_pkg::INDEX_W;
  localparam int IN_TDATA_W   = bt_pkg::IN_TDATA_W;
  localparam int OUT_TDATA_W  = bt_pkg::OUT_TDATA_W;
  localparam int MAX_LEN      = bt_pkg::MAX_LEN_DEF;
  localparam int RAND_ITEMS   = 300;
  localparam int SETTLE       = 4;
  localparam int TAIL_CYCLES  = 48;
  localparam int CALM_TAIL    = 40;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam longint ACC_HI   = 64'sd536870911;
  localparam longint ACC_LO   = -64'sd536870912;

  typedef enum logic [1:0] {CMD_SAMPLE, CMD_DIR, CMD_HOLD} cmd_kind_t;

  typedef struct {
    cmd_kind_t              kind;
    logic [SAMPLE_W-1:0]    smp;
    logic                   lst;
    logic                   dir;
  } stim_cmd_t;

  typedef struct {
    logic [COEF_W-1:0]  coef;
    logic [INDEX_W-1:0] idx;
    logic               lastf;
  } coef_beat_t;

  logic clk;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic out_tlast;

  stim_cmd_t  cmd_q[$];
  coef_beat_t coef_q[$];
  int         results_owed = 0;
  int         mismatches = 0;
  int         n_samples = 0;
  int         cycle_cnt = 0;

  // predictor state
  logic                dir_m;
  logic [ROW_W-1:0]    row_m[MAX_LEN];
  longint              acc_m[MAX_LEN];
  int                  pos_m;

  binomial_transform_top #(.MAX_LEN(MAX_LEN)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  function automatic void clear_vector();
    int j;
    for (j = 0; j < MAX_LEN; j++) begin
      row_m[j] = '0;
      acc_m[j] = 0;
    end
    row_m[0] = ROW_W'(1);
    pos_m = 0;
  endfunction

  // advance the Pascal row, accumulate one sample, emit coefficients on close
  function automatic void absorb_sample(input logic signed [SAMPLE_W-1:0] smp,
                                        input logic lst);
    int j;
    int pos;
    longint term;
    longint sum;
    coef_beat_t beat;
    pos = (pos_m >= MAX_LEN) ? MAX_LEN - 1 : pos_m;
    for (j = pos; j > 0; j--)
      row_m[j] = row_m[j] + row_m[j-1];
    for (j = 0; j <= pos; j++) begin
      term = longint'(smp) * longint'({1'b0, row_m[j]});
      if (dir_m && ((pos + j) % 2 == 1))
        term = -term;
      sum = acc_m[j] + term;
      if (sum > ACC_HI)
        sum = ACC_HI;
      else if (sum < ACC_LO)
        sum = ACC_LO;
      acc_m[j] = sum;
    end
    pos_m = pos + 1;
    if (lst || pos_m >= MAX_LEN) begin
      for (j = 0; j < pos_m; j++) begin
        beat.coef  = acc_m[j][COEF_W-1:0];
        beat.idx   = j[INDEX_W-1:0];
        beat.lastf = (j == pos_m - 1);
        coef_q.push_back(beat);
      end
      clear_vector();
    end
  endfunction

  function automatic void push_sample(input logic [SAMPLE_W-1:0] smp, input logic lst);
    stim_cmd_t c;
    c.kind = CMD_SAMPLE;
    c.smp  = smp;
    c.lst  = lst;
    c.dir  = 1'b0;
    cmd_q.push_back(c);
    n_samples++;
  endfunction

  function automatic void push_dir(input logic d);
    stim_cmd_t c;
    c.kind = CMD_DIR;
    c.smp  = '0;
    c.lst  = 1'b0;
    c.dir  = d;
    cmd_q.push_back(c);
  endfunction

  function automatic void push_hold();
    stim_cmd_t c;
    c.kind = CMD_HOLD;
    c.smp  = '0;
    c.lst  = 1'b0;
    c.dir  = 1'b0;
    cmd_q.push_back(c);
  endfunction

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'($signed($urandom_range(0, 16)) - 8);
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // len samples; last set on the final one only when close is 1
  function automatic void push_vector(input int len, input logic close);
    int k;
    for (k = 0; k < len; k++)
      push_sample(rand_sample(), close && (k == len - 1));
  endfunction

  // driver: input beats, direction writes, hold-offs, and receiver stalls
  int  in_gap = 0;
  int  out_stall = 0;
  int  quiet_cnt = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid  <= 1'b0;
      in_tdata   <= '0;
      in_tlast   <= 1'b0;
      cfg_we     <= 1'b0;
      cfg_wdata  <= 1'b0;
      out_tready <= 1'b0;
    end else begin
      if (results_owed == 0 && !in_tvalid)
        quiet_cnt++;
      else
        quiet_cnt = 0;
      if (cfg_we)
        cfg_we <= 1'b0;

      if (in_tvalid && !in_tready) begin
        // hold the beat until taken
      end else if (in_gap > 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (cmd_q.size() == 0) begin
        in_tvalid <= 1'b0;
      end else begin
        case (cmd_q[0].kind)
          CMD_SAMPLE: begin
            in_tvalid <= 1'b1;
            in_tdata  <= cmd_q[0].smp;
            in_tlast  <= cmd_q[0].lst;
            void'(cmd_q.pop_front());
            if (cmd_q.size() >= CALM_TAIL && $urandom_range(0, 7) == 0)
              in_gap = $urandom_range(1, 15);
          end
          CMD_DIR: begin
            in_tvalid <= 1'b0;
            // no write while the strobe is still high, so it drops between writes
            if (quiet_cnt >= SETTLE && !cfg_we) begin
              cfg_we    <= 1'b1;
              cfg_wdata <= cmd_q[0].dir;
              void'(cmd_q.pop_front());
            end
          end
          CMD_HOLD: begin
            in_tvalid <= 1'b0;
            if (quiet_cnt >= SETTLE)
              void'(cmd_q.pop_front());
          end
          default: in_tvalid <= 1'b0;
        endcase
      end

      if (out_stall > 0) begin
        out_stall--;
        out_tready <= 1'b0;
      end else if (cmd_q.size() >= CALM_TAIL && $urandom_range(0, 7) == 0) begin
        out_stall = $urandom_range(1, 15) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // monitor: tracks direction writes, predicts on input beats, checks output beats
  coef_beat_t want;
  always @(posedge clk) begin
    if (!rst_n) begin
      dir_m = 1'b0;
      clear_vector();
      coef_q.delete();
      results_owed <= 0;
    end else begin
      if (cfg_we)
        dir_m = cfg_wdata;
      if (out_tvalid && out_tready) begin
        if (coef_q.size() == 0) begin
          $error("unexpected coefficient beat: tdata=%h tlast=%b", out_tdata, out_tlast);
          mismatches++;
        end else begin
          want = coef_q.pop_front();
          if (out_tdata[COEF_W-1:0] !== want.coef) begin
            $error("coefficient: expected %0d, got %0d", $signed(want.coef),
                   $signed(out_tdata[COEF_W-1:0]));
            mismatches++;
          end
          if (out_tdata[COEF_W+INDEX_W-1:COEF_W] !== want.idx) begin
            $error("index: expected %0d, got %0d", want.idx,
                   out_tdata[COEF_W+INDEX_W-1:COEF_W]);
            mismatches++;
          end
          if (out_tlast !== want.lastf) begin
            $error("last_out: expected %b, got %b", want.lastf, out_tlast);
            mismatches++;
          end
        end
      end
      if (in_tvalid && in_tready)
        absorb_sample(in_tdata, in_tlast);
      results_owed <= coef_q.size();
    end
  end

  initial begin
    int r;
    int len;
    int target;

    // directed part
    push_dir(1'b0);
    push_sample(16'h7FFF, 1'b1);
    push_dir(1'b1);
    push_sample(16'h8000, 1'b0);
    push_sample(16'h7FFF, 1'b0);
    push_sample(16'hFFFF, 1'b1);
    push_dir(1'b0);
    // full-length vector: closes on its sixteenth sample with last never set
    for (int k = 0; k < MAX_LEN; k++)
      push_sample(16'h8000, 1'b0);
    // direction flipped partway through a vector
    push_sample(16'h7FFF, 1'b0);
    push_sample(16'h1234, 1'b0);
    push_hold();
    push_dir(1'b1);
    push_sample(16'h8000, 1'b0);
    push_sample(16'h0001, 1'b1);
    push_hold();

    // random part
    target = n_samples + RAND_ITEMS;
    while (n_samples < target) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        push_dir(1'($urandom_range(0, 1)));
      end else if (r < 12) begin
        push_hold();
      end else if (r < 22) begin
        push_vector($urandom_range(1, 8), 1'b0);
        push_dir(1'($urandom_range(0, 1)));
        push_vector($urandom_range(1, 8), 1'b1);
      end else if (r < 30) begin
        push_vector(MAX_LEN, 1'b0);
      end else if (r < 35) begin
        push_vector($urandom_range(MAX_LEN + 1, MAX_LEN + 4), 1'b1);
      end else begin
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : $urandom_range(1, MAX_LEN);
        push_vector(len, 1'b1);
      end
    end
    push_dir(1'b0);
    push_vector($urandom_range(1, MAX_LEN), 1'b1);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    @(negedge clk);
    while ((cmd_q.size() != 0 || in_tvalid || coef_q.size() != 0 || results_owed != 0)
           && cycle_cnt < CYCLE_LIMIT)
      @(negedge clk);
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d coefficient beats outstanding",
               cycle_cnt, coef_q.size());
      mismatches++;
    end else begin
      repeat (TAIL_CYCLES) @(posedge clk);
    end
    if (coef_q.size() != 0) begin
      $error("%0d expected coefficient beats never arrived", coef_q.size());
      mismatches++;
    end
    if (mismatches == 0)
      $display("** binomial_transform_top: PASSED **");
    else
      $display("** binomial_transform_top: FAILED **");
    $finish;
  end

endmodule

[filelist.f]
+incdir+src
src/bt_pkg.sv
src/bt_cell.sv
src/binomial_transform_top.sv
src/bt_checker.sv
test/binomial_transform_top_tb.sv
